// ===== sv/tsin_pkg.sv =====
// Shared types and fixed-point constants for the Taylor-series sine pipeline.
`timescale 1ns / 1ps
`default_nettype none

package tsin_pkg;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 32;
  localparam int WORD_W  = 64;
  localparam int LIMB_W  = 32;
  localparam int FRAC_BITS = 48;

  // The term recurrence runs in Q.48 and the angle comes in as Q.28.
  localparam int TERM_ALIGN = FRAC_BITS - 28;
  localparam int SQ_SHIFT   = 8;
  localparam int RND_SHIFT  = 18;

  // Each wide multiply registers its partial products, then registers their combined product.
  localparam int MUL_LAT  = 2;
  localparam int CELL_LAT = 2 * MUL_LAT;

  localparam logic [WORD_W-1:0] RND_HALF = WORD_W'(1) << (RND_SHIFT - 1);
  localparam logic [30:0]       ONE_Q30  = 31'h4000_0000;

  typedef logic [WORD_W-1:0] word_t;

  // What one series cell hands to the next.
  typedef struct packed {
    logic  vld;
    logic  tneg;
    word_t xsq;
    word_t term;
    word_t sum;
  } link_t;

endpackage

`default_nettype wire

// ===== sv/tsin_mulshr.sv =====
// Two-stage pipelined 64x64 multiply that returns the full product shifted right by SHIFT.
`timescale 1ns / 1ps
`default_nettype none

module tsin_mulshr #(
  parameter int SHIFT = 64
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire tsin_pkg::word_t     a_in,
  input  wire tsin_pkg::word_t     b_in,
  output tsin_pkg::word_t          prod_out
);

  localparam int LW = tsin_pkg::LIMB_W;
  localparam int WW = tsin_pkg::WORD_W;

  tsin_pkg::word_t p00_r, p01_r, p10_r, p11_r;
  tsin_pkg::word_t prod_r;
  tsin_pkg::word_t prod_nxt;

  logic [LW+1:0]   mid;
  tsin_pkg::word_t hi;
  tsin_pkg::word_t lo;
  logic [2*WW-1:0] full;

  // Stage one: four 32x32 partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= WW'(a_in[LW-1:0])  * WW'(b_in[LW-1:0]);
      p01_r <= WW'(a_in[LW-1:0])  * WW'(b_in[WW-1:LW]);
      p10_r <= WW'(a_in[WW-1:LW]) * WW'(b_in[LW-1:0]);
      p11_r <= WW'(a_in[WW-1:LW]) * WW'(b_in[WW-1:LW]);
    end
  end

  // Stage two: carry the cross terms into the upper half and pick the window.
  always_comb begin
    mid = (LW+2)'(p00_r[WW-1:LW]) + (LW+2)'(p01_r[LW-1:0]) + (LW+2)'(p10_r[LW-1:0]);
    hi  = p11_r + WW'(p01_r[WW-1:LW]) + WW'(p10_r[WW-1:LW]) + WW'(mid[LW+1:LW]);
    lo  = {mid[LW-1:0], p00_r[LW-1:0]};
    full = {hi, lo};
    prod_nxt = full[SHIFT +: WW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_out = prod_r;

endmodule

`default_nettype wire

// ===== sv/tsin_cell.sv =====
// One series cell: adds the current term into the sum and forms the next term.
`timescale 1ns / 1ps
`default_nettype none

module tsin_cell #(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire tsin_pkg::link_t  link_in,
  output tsin_pkg::link_t       link_out
);

  localparam int LAT = tsin_pkg::CELL_LAT;
  localparam int MLAT = tsin_pkg::MUL_LAT;
  localparam logic [63:0] DENOM = 64'((2 * IDX + 3) * (2 * IDX + 2));
  localparam logic [63:0] RECIP = {64{1'b1}} / DENOM;

  tsin_pkg::word_t sum_nxt;
  tsin_pkg::word_t ratio;
  tsin_pkg::word_t term_next;

  logic            vld_d_r  [0:LAT-1];
  logic            tneg_d_r [0:LAT-1];
  tsin_pkg::word_t xsq_d_r  [0:LAT-1];
  tsin_pkg::word_t sum_d_r  [0:LAT-1];
  tsin_pkg::word_t term_d_r [0:MLAT-1];

  assign sum_nxt = link_in.tneg ? (link_in.sum - link_in.term) : (link_in.sum + link_in.term);

  // ratio = x*x / ((2i+3)(2i+2)) in Q.48, then next term = term * ratio.
  tsin_mulshr #(.SHIFT(64)) u_ratio (
    .clk      (clk),
    .en       (en),
    .a_in     (link_in.xsq),
    .b_in     (RECIP),
    .prod_out (ratio)
  );

  tsin_mulshr #(.SHIFT(tsin_pkg::FRAC_BITS)) u_term (
    .clk      (clk),
    .en       (en),
    .a_in     (term_d_r[MLAT-1]),
    .b_in     (ratio),
    .prod_out (term_next)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_d_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_d_r[0] <= link_in.vld;
      for (int k = 1; k < LAT; k++) begin
        vld_d_r[k] <= vld_d_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tneg_d_r[0] <= link_in.tneg;
      xsq_d_r[0]  <= link_in.xsq;
      sum_d_r[0]  <= sum_nxt;
      term_d_r[0] <= link_in.term;
      for (int k = 1; k < LAT; k++) begin
        tneg_d_r[k] <= tneg_d_r[k-1];
        xsq_d_r[k]  <= xsq_d_r[k-1];
        sum_d_r[k]  <= sum_d_r[k-1];
      end
      for (int k = 1; k < MLAT; k++) begin
        term_d_r[k] <= term_d_r[k-1];
      end
    end
  end

  // Every term alternates in sign.
  assign link_out = '{vld:  vld_d_r[LAT-1],
                      tneg: !tneg_d_r[LAT-1],
                      xsq:  xsq_d_r[LAT-1],
                      term: term_next,
                      sum:  sum_d_r[LAT-1]};

endmodule

`default_nettype wire

// ===== sv/taylor_sine_top.sv =====
// Top level of the fixed-point Taylor-series sine pipeline.
// Usage:
//   The input channel (in_valid, in_stall, in_angle) takes one angle in radians,
//   signed Q3.28, per transaction. The output channel (out_valid, out_stall,
//   out_sine_value) returns its sine as signed Q1.30, saturated to plus or minus one.
//   Results leave in the order the angles arrived, one per angle.
//   An accepted angle passes the front-end registers, the series cells, the back-end
//   registers and the output register. Each series cell runs the pipelined 64-bit
//   ratio multiply and then the pipelined term multiply.
//   Throughput is one angle per cycle while in_stall is low.
//   When the receiver stalls, the result waits in the output register while the
//   pipeline keeps moving until a finished result reaches its last stage; only
//   then is in_stall raised.
//   A synchronous reset (rst_n low) empties the pipeline and the output register.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_top #(
  parameter int TERM_COUNT = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_sine_value
);

  localparam int AW = tsin_pkg::ANGLE_W;
  localparam int OW = tsin_pkg::OUT_W;

  logic advance;

  logic            p0_vld_r, p0_xneg_r;
  logic [AW-1:0]   p0_ax_r;
  logic [AW-1:0]   ax_nxt;

  logic            p1_vld_r, p1_tneg_r;
  tsin_pkg::word_t p1_xsq_r, p1_term_r;
  tsin_pkg::word_t ax_sq;

  tsin_pkg::link_t link [0:TERM_COUNT];

  logic            q0_vld_r, q0_sneg_r;
  tsin_pkg::word_t q0_mag_r;
  tsin_pkg::word_t sum_last;

  logic            q1_vld_r, q1_sneg_r;
  logic [30:0]     q1_mag_r;
  tsin_pkg::word_t rnd;
  logic [30:0]     q_sat;

  logic            out_valid_r;
  logic [OW-1:0]   out_value_r;
  logic            out_load;

  // The output register frees up when it is empty or its transaction completes.
  assign out_load = !out_valid_r || !out_stall;
  assign advance  = out_load || !q1_vld_r;
  assign in_stall = !advance;

  // Front end: magnitude of the angle, then x*x and the first term.
  assign ax_nxt = in_angle[AW-1] ? (AW'(0) - AW'(in_angle)) : AW'(in_angle);
  assign ax_sq  = tsin_pkg::word_t'(p0_ax_r) * tsin_pkg::word_t'(p0_ax_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      q0_vld_r <= 1'b0;
      q1_vld_r <= 1'b0;
    end else if (advance) begin
      p0_vld_r <= in_valid;
      p1_vld_r <= p0_vld_r;
      q0_vld_r <= link[TERM_COUNT].vld;
      q1_vld_r <= q0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p0_ax_r   <= ax_nxt;
      p0_xneg_r <= in_angle[AW-1];
      p1_xsq_r  <= ax_sq >> tsin_pkg::SQ_SHIFT;
      p1_term_r <= tsin_pkg::word_t'(p0_ax_r) << tsin_pkg::TERM_ALIGN;
      p1_tneg_r <= p0_xneg_r;
    end
  end

  assign link[0] = '{vld:  p1_vld_r,
                     tneg: p1_tneg_r,
                     xsq:  p1_xsq_r,
                     term: p1_term_r,
                     sum:  '0};

  for (genvar i = 0; i < TERM_COUNT; i++) begin : g_cell
    tsin_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  // Back end: magnitude of the sum, round half away from zero, saturate, sign.
  assign sum_last = link[TERM_COUNT].sum;
  assign rnd      = q0_mag_r + tsin_pkg::RND_HALF;

  always_comb begin
    if (rnd[63:tsin_pkg::RND_SHIFT] > (64 - tsin_pkg::RND_SHIFT)'(tsin_pkg::ONE_Q30)) begin
      q_sat = tsin_pkg::ONE_Q30;
    end else begin
      q_sat = rnd[tsin_pkg::RND_SHIFT +: 31];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q0_sneg_r <= sum_last[63];
      q0_mag_r  <= sum_last[63] ? (tsin_pkg::word_t'(0) - sum_last) : sum_last;
      q1_sneg_r <= q0_sneg_r;
      q1_mag_r  <= q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= q1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= q1_sneg_r ? (OW'(0) - OW'(q1_mag_r)) : OW'(q1_mag_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_value_r;

endmodule

`default_nettype wire

// ===== sv/tsin_checker.sv =====
// Port-level assertions for the Taylor-series sine block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module tsin_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [31:0] in_angle,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_sine_value
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled input transaction stays offered with the same angle.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_angle))
    else $error("stalled angle changed");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sine_value))
    else $error("stalled result changed");

  // The input side only backs up when a result is held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall raised while the output side is free");

  // Results are saturated to plus or minus one in Q1.30.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine_value <= 32'sd1073741824) &&
                  (out_sine_value >= -32'sd1073741824))
    else $error("sine result out of range");

endmodule

bind taylor_sine_top tsin_checker u_tsin_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_angle       (in_angle),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sine_value (out_sine_value)
);

`default_nettype wire
